[hw/rtl/reprojection_inlier_check_top_macros.svh]
// Assertion macros used by the top RTL file of the inlier check block.
`ifndef REPROJECTION_INLIER_CHECK_TOP_MACROS_SVH
`define REPROJECTION_INLIER_CHECK_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RICH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define RICH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/rich_pkg.sv]
//------------------------------------------------------------------------------
// rich_pkg
// Types, constants and microcode tables of the reprojection inlier check.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rich_pkg;

  localparam int STORE_WORDS = 44;
  localparam int NUM_REGS    = 22;

  localparam logic [4:0] R_P1X  = 5'd0;
  localparam logic [4:0] R_P2X  = 5'd3;
  localparam logic [4:0] R_AX   = 5'd6;
  localparam logic [4:0] R_BX   = 5'd9;
  localparam logic [4:0] R_QX   = 5'd12;
  localparam logic [4:0] R_QY   = 5'd13;
  localparam logic [4:0] R_O1U  = 5'd14;
  localparam logic [4:0] R_O2U  = 5'd16;
  localparam logic [4:0] R_X21U = 5'd18;
  localparam logic [4:0] R_X12U = 5'd20;

  localparam logic [5:0] K1_BASE  = 6'd24;
  localparam logic [5:0] K2_BASE  = 6'd28;
  localparam logic [5:0] FWD_BASE = 6'd0;
  localparam logic [5:0] INV_BASE = 6'd12;
  localparam logic [5:0] RIG_ROT  = 6'd32;
  localparam logic [5:0] RIG_TRN  = 6'd41;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TEST  = 2'd1,
    ACT_FINAL = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    OP_ACCT, OP_MAC, OP_SAT, OP_DEN, OP_DIV, OP_CLR,
    OP_LDH, OP_SUB, OP_SQ, OP_CMP, OP_CPY
  } op_e_t;

  typedef enum logic [2:0] {
    TK_PROJ, TK_APPLY, TK_COPY, TK_ERR, TK_END
  } kind_t;

  typedef enum logic [1:0] {
    COND_ALWAYS, COND_FLAG0, COND_FLAG1
  } cond_t;

  typedef struct packed {
    op_e_t      opc;
    logic [5:0] coef;
    logic [4:0] src;
    logic [4:0] dst;
    logic       last;
  } op_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] src;
    logic [4:0] dst;
    logic [5:0] cbase;
    logic       rig;
    cond_t      cond;
  } task_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic task_t task_rom(input logic [3:0] idx);
    task_t t;
    t = '{TK_END, 5'd0, 5'd0, 6'd0, 1'b0, COND_ALWAYS};
    unique case (idx)
      4'd0:  t = '{TK_PROJ,  R_P1X,  R_O1U,  K1_BASE,  1'b0, COND_ALWAYS};
      4'd1:  t = '{TK_PROJ,  R_P2X,  R_O2U,  K2_BASE,  1'b0, COND_ALWAYS};
      4'd2:  t = '{TK_APPLY, R_P2X,  R_AX,   FWD_BASE, 1'b0, COND_ALWAYS};
      4'd3:  t = '{TK_APPLY, R_AX,   R_BX,   RIG_ROT,  1'b1, COND_FLAG1};
      4'd4:  t = '{TK_COPY,  R_BX,   R_AX,   6'd0,     1'b0, COND_FLAG1};
      4'd5:  t = '{TK_PROJ,  R_AX,   R_X21U, K1_BASE,  1'b0, COND_ALWAYS};
      4'd6:  t = '{TK_APPLY, R_P1X,  R_AX,   INV_BASE, 1'b0, COND_ALWAYS};
      4'd7:  t = '{TK_APPLY, R_AX,   R_BX,   RIG_ROT,  1'b1, COND_FLAG0};
      4'd8:  t = '{TK_COPY,  R_BX,   R_AX,   6'd0,     1'b0, COND_FLAG0};
      4'd9:  t = '{TK_PROJ,  R_AX,   R_X12U, K2_BASE,  1'b0, COND_ALWAYS};
      4'd10: t = '{TK_ERR,   R_O1U,  R_X21U, 6'd0,     1'b0, COND_ALWAYS};
      4'd11: t = '{TK_ERR,   R_X12U, R_O2U,  6'd1,     1'b0, COND_ALWAYS};
      default: t = '{TK_END, 5'd0, 5'd0, 6'd0, 1'b0, COND_ALWAYS};
    endcase
    return t;
  endfunction

  function automatic op_t op_dec(input task_t t, input logic [1:0] row, input logic [3:0] k);
    op_t        o;
    logic [5:0] r6;
    logic [4:0] r5;
    logic [5:0] km1;
    r6  = {4'd0, row};
    r5  = {3'd0, row};
    km1 = {2'd0, k} - 6'd1;
    o   = '{OP_CLR, 6'd0, 5'd0, 5'd0, 1'b1};
    case (t.kind)
      TK_PROJ: begin
        case (k)
          4'd0: o = '{OP_DEN,  6'd0, t.src + 5'd2, 5'd0, 1'b0};
          4'd1: o = '{OP_DIV,  6'd0, t.src, R_QX, 1'b0};
          4'd2: o = '{OP_DIV,  6'd0, t.src + 5'd1, R_QY, 1'b0};
          4'd3: o = '{OP_ACCT, t.cbase + 6'd2, 5'd0, 5'd0, 1'b0};
          4'd4: o = '{OP_MAC,  t.cbase, R_QX, 5'd0, 1'b0};
          4'd5: o = '{OP_SAT,  6'd0, 5'd0, t.dst, 1'b0};
          4'd6: o = '{OP_ACCT, t.cbase + 6'd3, 5'd0, 5'd0, 1'b0};
          4'd7: o = '{OP_MAC,  t.cbase + 6'd1, R_QY, 5'd0, 1'b0};
          default: o = '{OP_SAT, 6'd0, 5'd0, t.dst + 5'd1, 1'b1};
        endcase
      end
      TK_APPLY: begin
        case (k)
          4'd0: o = '{OP_ACCT, t.rig ? (RIG_TRN + r6) : (t.cbase + {r6[3:0], 2'b00} + 6'd3),
                      5'd0, 5'd0, 1'b0};
          4'd1, 4'd2, 4'd3:
            o = '{OP_MAC, t.rig ? (t.cbase + {r6[4:0], 1'b0} + r6 + km1)
                                : (t.cbase + {r6[3:0], 2'b00} + km1),
                  t.src + km1[4:0], 5'd0, 1'b0};
          default: o = '{OP_SAT, 6'd0, 5'd0, t.dst + r5, 1'b1};
        endcase
      end
      TK_COPY: o = '{OP_CPY, 6'd0, t.src + r5, t.dst + r5, 1'b1};
      TK_ERR: begin
        case (k)
          4'd0: o = '{OP_CLR, 6'd0, 5'd0, 5'd0, 1'b0};
          4'd1: o = '{OP_LDH, 6'd0, t.src, 5'd0, 1'b0};
          4'd2: o = '{OP_SUB, 6'd0, t.dst, 5'd0, 1'b0};
          4'd3: o = '{OP_SQ,  6'd0, 5'd0, 5'd0, 1'b0};
          4'd4: o = '{OP_LDH, 6'd0, t.src + 5'd1, 5'd0, 1'b0};
          4'd5: o = '{OP_SUB, 6'd0, t.dst + 5'd1, 5'd0, 1'b0};
          4'd6: o = '{OP_SQ,  6'd0, 5'd0, 5'd0, 1'b0};
          default: o = '{OP_CMP, 6'd0, 5'd0, {4'd0, t.cbase[0]}, 1'b1};
        endcase
      end
      default: o = '{OP_CLR, 6'd0, 5'd0, 5'd0, 1'b1};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rich_ram.sv]
//------------------------------------------------------------------------------
// rich_ram
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rich_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/rich_div.sv]
//------------------------------------------------------------------------------
// rich_div
// Radix-2 restoring divider for depth quotients x * 2^FRAC_BITS / z,
// truncated toward zero and saturated to signed 32 bits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rich_div
  import rich_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done_r,
  output logic [31:0]      quo
);

  localparam int N  = 32 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0]  dvd_r;
  logic [32:0]   rem_r;
  logic [31:0]   dmag_r;
  logic          neg_r;
  logic [32:0]   trial;
  logic          qbit;
  logic [31:0]   nmag;
  logic [31:0]   dmag;

  assign nmag  = num[31] ? (32'd0 - num) : num;
  assign dmag  = den[31] ? (32'd0 - den) : den;
  assign trial = {rem_r[31:0], dvd_r[N-1]};
  assign qbit  = (trial >= {1'b0, dmag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        dvd_r  <= {nmag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dmag_r <= dmag;
        neg_r  <= num[31] ^ den[31];
      end else if (busy_r) begin
        rem_r <= qbit ? (trial - {1'b0, dmag_r}) : trial;
        dvd_r <= {dvd_r[N-2:0], qbit};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      if (dvd_r > N'(33'h080000000)) begin
        quo = 32'h80000000;
      end else begin
        quo = 32'd0 - dvd_r[31:0];
      end
    end else if (dvd_r[N-1:31] != '0) begin
      quo = 32'h7FFFFFFF;
    end else begin
      quo = dvd_r[31:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/reprojection_inlier_check_top.sv]
// Load words give no result; the block is ready again next cycle.
// A test word runs about 82 to 118 micro-operations on one shared 32x32 multiplier
// and accumulator, plus up to eight divisions; a zero depth skips its divisions.
// One test word is in flight at a time.
// Synchronous reset clears the sequencer, the output valid and the inlier count.
//------------------------------------------------------------------------------
// reprojection_inlier_check_top
// Symmetric reprojection inlier test of a matched 3D point pair, microcoded
// over a shared multiply-accumulate unit and an iterative divider.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "reprojection_inlier_check_top_macros.svh"

module reprojection_inlier_check_top
  import rich_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // coef_index, coef_value, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, cam_flags,
  // max_error1, max_error2
  input  wire logic [295:0] in_tdata,
  // action
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // inlier, running_count, zero fill
  output logic [15:0]       out_tdata,
  // depth_fault
  output logic              out_tuser,
  // set_done
  output logic              out_tlast
);

  localparam int          CAP_INT = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;
  localparam logic [10:0] CNT_CAP = 11'(CAP_INT);
  localparam int          AW      = $clog2(STORE_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_TASK, S_FETCH, S_EXEC, S_WB, S_DIVW, S_DONE
  } state_t;

  state_t             state_r;
  logic [3:0]         task_r;
  logic [1:0]         row_r;
  logic [3:0]         k_r;
  logic [31:0]        rf_r [NUM_REGS];
  logic [31:0]        opnd_r;
  logic [31:0]        hold_r;
  logic [31:0]        diff_r;
  logic [31:0]        den_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic [31:0]        max1_r;
  logic [31:0]        max2_r;
  logic [1:0]         flags_r;
  logic               final_r;
  logic               fault_r;
  logic [1:0]         pass_r;
  logic [10:0]        cnt_r;
  logic [10:0]        cnt_nxt;
  logic               inl;
  logic               out_valid_r;
  logic [15:0]        out_data_r;
  logic               out_user_r;
  logic               out_last_r;

  logic               in_acc;
  act_t               act;
  task_t              tk;
  op_t                op;
  logic               cond_ok;
  logic [31:0]        ram_rdata;
  logic               ram_we;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic [31:0]        max_sel;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign act       = act_t'(in_tuser);
  assign ram_we    = in_acc && (act == ACT_LOAD) && (in_tdata[5:0] < 6'(STORE_WORDS));

  assign tk = task_rom(task_r);
  assign op = op_dec(tk, row_r, k_r);

  always_comb begin
    case (tk.cond)
      COND_FLAG0: cond_ok = flags_r[0];
      COND_FLAG1: cond_ok = flags_r[1];
      default:    cond_ok = 1'b1;
    endcase
  end

  assign mul_a     = (op.opc == OP_SQ) ? diff_r : ram_rdata;
  assign mul_b     = (op.opc == OP_SQ) ? diff_r : opnd_r;
  assign max_sel   = op.dst[0] ? max2_r : max1_r;
  assign div_start = (state_r == S_EXEC) && (op.opc == OP_DIV) && (den_r != '0);

  assign inl     = !fault_r && pass_r[0] && pass_r[1];
  assign cnt_nxt = (inl && (cnt_r < CNT_CAP)) ? (cnt_r + 11'd1) : cnt_r;

  rich_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_coef_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (in_tdata[AW-1:0]),
    .wdata   (in_tdata[37:6]),
    .raddr   (op.coef[AW-1:0]),
    .rdata_r (ram_rdata)
  );

  rich_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (opnd_r),
    .den    (den_r),
    .done_r (div_done),
    .quo    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      task_r      <= '0;
      row_r       <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      fault_r     <= 1'b0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && ((act == ACT_TEST) || (act == ACT_FINAL))) begin
            rf_r[R_P1X]           <= in_tdata[69:38];
            rf_r[R_P1X + 5'd1]    <= in_tdata[101:70];
            rf_r[R_P1X + 5'd2]    <= in_tdata[133:102];
            rf_r[R_P2X]           <= in_tdata[165:134];
            rf_r[R_P2X + 5'd1]    <= in_tdata[197:166];
            rf_r[R_P2X + 5'd2]    <= in_tdata[229:198];
            flags_r <= in_tdata[231:230];
            max1_r  <= in_tdata[263:232];
            max2_r  <= in_tdata[295:264];
            final_r <= (act == ACT_FINAL);
            fault_r <= 1'b0;
            pass_r  <= '0;
            task_r  <= '0;
            state_r <= S_TASK;
          end
        end
        S_TASK: begin
          row_r <= '0;
          k_r   <= '0;
          if (tk.kind == TK_END) begin
            state_r <= S_DONE;
          end else if (!cond_ok) begin
            task_r <= task_r + 4'd1;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          opnd_r  <= rf_r[op.src];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= div_start ? S_DIVW : S_WB;
          case (op.opc)
            OP_ACCT: acc_r  <= {{32{ram_rdata[31]}}, ram_rdata};
            OP_MAC, OP_SQ: prod_r <= mul_a * mul_b;
            OP_SAT:  rf_r[op.dst] <= sat32(acc_r);
            OP_DEN: begin
              den_r <= opnd_r;
              if (opnd_r == '0) begin
                fault_r <= 1'b1;
              end
            end
            OP_DIV: begin
              if (den_r == '0) begin
                rf_r[op.dst] <= '0;
              end
            end
            OP_CLR:  acc_r  <= '0;
            OP_LDH:  hold_r <= opnd_r;
            OP_SUB:  diff_r <= sat32(64'($signed(hold_r)) - 64'($signed(opnd_r)));
            OP_CMP:  pass_r[op.dst[0]] <= (acc_r < $signed({32'd0, max_sel}));
            OP_CPY:  rf_r[op.dst] <= opnd_r;
            default: acc_r  <= acc_r;
          endcase
        end
        S_DIVW: begin
          if (div_done) begin
            rf_r[op.dst] <= div_quo;
            state_r      <= S_WB;
          end
        end
        S_WB: begin
          if ((op.opc == OP_MAC) || (op.opc == OP_SQ)) begin
            acc_r <= acc_r + (prod_r >>> FRAC_BITS);
          end
          if (op.last) begin
            k_r <= '0;
            if (((tk.kind == TK_APPLY) || (tk.kind == TK_COPY)) && (row_r != 2'd2)) begin
              row_r   <= row_r + 2'd1;
              state_r <= S_FETCH;
            end else begin
              task_r  <= task_r + 4'd1;
              state_r <= S_TASK;
            end
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {4'd0, cnt_nxt, inl};
            out_user_r  <= fault_r;
            out_last_r  <= final_r;
            cnt_r       <= final_r ? 11'd0 : cnt_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `RICH_ASSERT(a_cnt_cap, cnt_r <= CNT_CAP, "inlier count above its cap")
  `RICH_ASSERT(a_inl_fault, (out_tvalid && out_tdata[0]) |-> !out_tuser, "inlier with depth fault")
  `RICH_ASSERT(a_final_clear, (state_r == S_DONE && final_r && (!out_valid_r || out_tready)) |=> (cnt_r == 11'd0), "count not cleared after final pair")
  `RICH_ASSERT(a_div_wait, div_done |-> (state_r == S_DIVW), "divider finished outside a divide")

endmodule

`default_nettype wire
